// ===== rtl/lert_pkg.sv =====
// types, constants and helpers shared by the longest equal run tracker
// no dependencies
`timescale 1ns / 1ps

package lert_pkg;

    localparam int LEAF_W     = 10;
    localparam int MAX_LEAVES = 1 << LEAF_W;
    localparam int ADDR_W     = LEAF_W + 1;
    localparam int DEPTH      = 2 * MAX_LEAVES;
    localparam int RUN_W      = LEAF_W + 1;
    localparam int CHAR_W     = 8;
    localparam int LVL_W      = $clog2(LEAF_W + 1);
    localparam int NODE_W     = 3 * RUN_W + 2 * CHAR_W;

    typedef struct packed {
        logic [RUN_W-1:0]  lead;
        logic [RUN_W-1:0]  trail;
        logic [RUN_W-1:0]  best;
        logic [CHAR_W-1:0] edge_lo;
        logic [CHAR_W-1:0] edge_hi;
    } node_t;

    // summary of a heap node over an all-zero string of len positions in use
    function automatic node_t clear_node(input logic [ADDR_W-1:0] idx,
                                         input logic [RUN_W-1:0] len);
        int                d;
        logic [ADDR_W-1:0] sh;
        logic [RUN_W-1:0]  lo;
        logic [RUN_W-1:0]  span;
        logic [RUN_W-1:0]  rem;
        logic [RUN_W-1:0]  v;
        node_t             n;
        d = 0;
        for (int i = 0; i < ADDR_W; i++) begin
            if (idx[i]) begin
                d = i;
            end
        end
        sh   = idx << (LEAF_W - d);
        lo   = {1'b0, sh[LEAF_W-1:0]};
        span = RUN_W'(MAX_LEAVES) >> d;
        rem  = len - lo;
        if (len > lo) begin
            v = (rem > span) ? span : rem;
        end else begin
            v = '0;
        end
        n.lead    = v;
        n.trail   = (v == span) ? span : '0;
        n.best    = v;
        n.edge_lo = '0;
        n.edge_hi = '0;
        return n;
    endfunction

endpackage

// ===== rtl/lert_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module lert_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/lert_join.sv =====
// merges two child summaries into their parent summary
// depends on lert_pkg
`timescale 1ns / 1ps

module lert_join (
    input  lert_pkg::node_t                a,
    input  lert_pkg::node_t                b,
    input  logic [lert_pkg::RUN_W-1:0]     span,
    output lert_pkg::node_t                p
);

    logic                          same;
    logic [lert_pkg::RUN_W-1:0]    mid;
    logic [lert_pkg::RUN_W-1:0]    big;

    assign same = (a.edge_hi == b.edge_lo);
    assign mid  = a.trail + b.lead;
    assign big  = (a.best > b.best) ? a.best : b.best;

    always_comb begin
        p.edge_lo = a.edge_lo;
        p.edge_hi = b.edge_hi;
        p.best    = (same && mid > big) ? mid : big;
        p.lead    = (same && a.lead == span) ? a.lead + b.lead : a.lead;
        p.trail   = (same && b.trail == span) ? b.trail + a.trail : b.trail;
    end

endmodule

// ===== rtl/longest_equal_run_tracker.sv =====
// top level: node store, update walk towards the root and clearing pass
// depends on lert_pkg, lert_ram, lert_join
//
// channel | dir | signals                         | contents
// s_      | in  | s_tvalid s_tready s_tdata[23:0] | position, character
// m_      | out | m_tvalid m_tready m_tdata m_tuser | longest_run, position_error
// cfg_    | in  | cfg_wr_en cfg_wr_data[10:0]     | length_in_use
//
// a write does the leaf write and sibling read (ST_START), then per tree level
// (10) one ram read and one ram write (ST_JOIN), then the result load (ST_DONE)
// the next request is taken only after the result is loaded
// an ignored position only reads the root (ST_ROOT) before the result load
// reset and every length write run a clearing pass over store nodes 1 to 2047
// a stalled result holds the block before it takes the next request
`timescale 1ns / 1ps

module longest_equal_run_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,      // position[9:0], character[17:10], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // longest_run[10:0], zero pad
    output logic [0:0]  m_tuser,      // position_error[0]
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_START, ST_ROOT, ST_JOIN, ST_DONE
    } state_t;

    state_t                                state_reg;
    logic [lert_pkg::RUN_W-1:0]            len_reg;
    logic [lert_pkg::ADDR_W-1:0]           clr_reg;
    logic [lert_pkg::LEAF_W-1:0]           pos_reg;
    logic [lert_pkg::CHAR_W-1:0]           ch_reg;
    logic [lert_pkg::ADDR_W-1:0]           idx_reg;
    logic [lert_pkg::LVL_W-1:0]            lvl_reg;
    lert_pkg::node_t                       cur_reg;
    logic [lert_pkg::RUN_W-1:0]            best_reg;
    logic                                  err_reg;
    logic                                  m_tvalid_reg;
    logic [lert_pkg::RUN_W-1:0]            out_run_reg;
    logic                                  out_err_reg;

    logic                                  wr_en;
    logic [lert_pkg::ADDR_W-1:0]           wr_addr;
    lert_pkg::node_t                       wr_node;
    logic [lert_pkg::ADDR_W-1:0]           rd_addr;
    logic [lert_pkg::NODE_W-1:0]           rd_raw;
    lert_pkg::node_t                       rd_node;
    lert_pkg::node_t                       join_a;
    lert_pkg::node_t                       join_b;
    lert_pkg::node_t                       joined;
    lert_pkg::node_t                       leaf;
    logic [lert_pkg::ADDR_W-1:0]           parent;
    logic [lert_pkg::ADDR_W-1:0]           leaf_addr;
    logic                                  in_range;
    logic [lert_pkg::RUN_W-1:0]            len_next;
    logic                                  out_load;

    assign rd_node   = lert_pkg::node_t'(rd_raw);
    assign leaf_addr = {1'b1, pos_reg};
    assign in_range  = ({1'b0, pos_reg} < len_reg);
    assign parent    = idx_reg >> 1;
    assign leaf      = '{lead: lert_pkg::RUN_W'(1), trail: lert_pkg::RUN_W'(1),
                         best: lert_pkg::RUN_W'(1), edge_lo: ch_reg, edge_hi: ch_reg};
    assign out_load  = (state_reg == ST_DONE) && !cfg_wr_en && (!m_tvalid_reg || m_tready);

    // current node sits left when its index is even
    assign join_a = idx_reg[0] ? rd_node : cur_reg;
    assign join_b = idx_reg[0] ? cur_reg : rd_node;

    always_comb begin
        if (cfg_wr_data == '0) begin
            len_next = lert_pkg::RUN_W'(1);
        end else if (cfg_wr_data > lert_pkg::RUN_W'(lert_pkg::MAX_LEAVES)) begin
            len_next = lert_pkg::RUN_W'(lert_pkg::MAX_LEAVES);
        end else begin
            len_next = cfg_wr_data;
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_node = lert_pkg::clear_node(clr_reg, len_reg);
        rd_addr = lert_pkg::ADDR_W'(1);
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
            end
            ST_START: begin
                if (in_range) begin
                    wr_en   = 1'b1;
                    wr_addr = leaf_addr;
                    wr_node = leaf;
                    rd_addr = leaf_addr ^ lert_pkg::ADDR_W'(1);
                end
            end
            ST_JOIN: begin
                wr_en   = 1'b1;
                wr_addr = parent;
                wr_node = joined;
                rd_addr = parent ^ lert_pkg::ADDR_W'(1);
            end
            default: begin
            end
        endcase
    end

    lert_ram #(
        .WIDTH(lert_pkg::NODE_W),
        .DEPTH(lert_pkg::DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_node),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    lert_join u_join (
        .a    (join_a),
        .b    (join_b),
        .span (lert_pkg::RUN_W'(1) << lvl_reg),
        .p    (joined)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            len_reg      <= lert_pkg::RUN_W'(lert_pkg::MAX_LEAVES);
            clr_reg      <= lert_pkg::ADDR_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                len_reg   <= len_next;
                clr_reg   <= lert_pkg::ADDR_W'(1);
                state_reg <= ST_CLEAR;
            end else begin
                unique case (state_reg)
                    ST_CLEAR: begin
                        clr_reg <= clr_reg + lert_pkg::ADDR_W'(1);
                        if (clr_reg == lert_pkg::ADDR_W'(lert_pkg::DEPTH - 1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    ST_IDLE: begin
                        if (s_tvalid) begin
                            pos_reg   <= s_tdata[lert_pkg::LEAF_W-1:0];
                            ch_reg    <= s_tdata[lert_pkg::LEAF_W +: lert_pkg::CHAR_W];
                            state_reg <= ST_START;
                        end
                    end
                    ST_START: begin
                        err_reg <= !in_range;
                        idx_reg <= leaf_addr;
                        cur_reg <= leaf;
                        lvl_reg <= '0;
                        state_reg <= in_range ? ST_JOIN : ST_ROOT;
                    end
                    ST_ROOT: begin
                        best_reg  <= rd_node.best;
                        state_reg <= ST_DONE;
                    end
                    ST_JOIN: begin
                        cur_reg <= joined;
                        idx_reg <= parent;
                        lvl_reg <= lvl_reg + lert_pkg::LVL_W'(1);
                        if (parent == lert_pkg::ADDR_W'(1)) begin
                            best_reg  <= joined.best;
                            state_reg <= ST_DONE;
                        end
                    end
                    ST_DONE: begin
                        if (out_load) begin
                            out_run_reg  <= best_reg;
                            out_err_reg  <= err_reg;
                            state_reg    <= ST_IDLE;
                        end
                    end
                    default: begin
                        state_reg <= ST_CLEAR;
                    end
                endcase
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !cfg_wr_en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(16 - lert_pkg::RUN_W){1'b0}}, out_run_reg};
    assign m_tuser  = out_err_reg;

endmodule

// ===== rtl/lert_checker.sv =====
// port-level checks for the longest equal run tracker, bound to the top level
// depends on longest_equal_run_tracker
`timescale 1ns / 1ps

module lert_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        cfg_wr_en
);

    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !s_tready)
        else $error("outputs active right after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request taken while one is in flight");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:0] <= 11'd1024) && (m_tdata[15:11] == 5'd0))
        else $error("run longer than the store");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("request accepted during clearing pass");

endmodule

bind longest_equal_run_tracker lert_props u_lert_props (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en)
);

// ===== tb/lert_checker.sv =====
// checker for the longest equal run tracker: watches both channels and the length register,
// predicts every result from its own copy of the string and compares in order
// depends on lert_pkg
`timescale 1ns / 1ps

module lert_checker
    import lert_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [RUN_W-1:0] longest_run;
        logic             position_error;
    } run_result_t;

    logic [CHAR_W-1:0] text [MAX_LEAVES];
    logic [RUN_W-1:0]  text_len;
    run_result_t       expected_runs [$];

    // longest stretch of equal characters among the positions in use
    function automatic logic [RUN_W-1:0] longest_stretch();
        int cur;
        int top;
        cur = 0;
        top = 0;
        for (int i = 0; i < MAX_LEAVES; i++) begin
            if (i >= text_len) begin
                break;
            end
            if (i > 0 && text[i] == text[i-1]) begin
                cur++;
            end else begin
                cur = 1;
            end
            if (cur > top) begin
                top = cur;
            end
        end
        if (top > 2047) begin
            top = 2047;
        end
        return RUN_W'(top);
    endfunction

    function automatic void clear_text(input logic [RUN_W-1:0] len);
        for (int i = 0; i < MAX_LEAVES; i++) begin
            text[i] = '0;
        end
        text_len = len;
    endfunction

    initial begin
        fail_count = 0;
        clear_text(RUN_W'(MAX_LEAVES));
    end

    assign pending = expected_runs.size();

    always @(posedge aclk) begin
        run_result_t       exp_r;
        logic [9:0]        pos;
        logic [CHAR_W-1:0] ch;
        logic [10:0]       len;
        if (!aresetn) begin
            clear_text(RUN_W'(MAX_LEAVES));
            expected_runs.delete();
        end else begin
            if (cfg_wr_en) begin
                len = cfg_wr_data;
                if (len == 11'd0) begin
                    len = 11'd1;
                end
                if (len > 11'(MAX_LEAVES)) begin
                    len = 11'(MAX_LEAVES);
                end
                clear_text(len);
            end
            if (s_tvalid && s_tready) begin
                pos = s_tdata[9:0];
                ch  = s_tdata[17:10];
                exp_r.position_error = 1'b1;
                if ({1'b0, pos} < text_len) begin
                    text[pos] = ch;
                    exp_r.position_error = 1'b0;
                end
                exp_r.longest_run = longest_stretch();
                expected_runs.push_back(exp_r);
            end
            if (m_tvalid && m_tready) begin
                if (expected_runs.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result: run %0d err %0d", m_tdata[10:0], m_tuser[0]);
                    end
                end else begin
                    exp_r = expected_runs.pop_front();
                    if (m_tdata[10:0] !== exp_r.longest_run
                        || m_tuser[0] !== exp_r.position_error) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: run exp %0d got %0d, err exp %0d got %0d",
                                     exp_r.longest_run, m_tdata[10:0],
                                     exp_r.position_error, m_tuser[0]);
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== tb/testbench.sv =====
// testbench top: clock, reset, request stimulus, result back-pressure and verdict
// depends on lert_pkg, lert_checker and the longest_equal_run_tracker rtl
`timescale 1ns / 1ps

module testbench;
    import lert_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_wr_en;
    logic [10:0] cfg_wr_data;
    int          fail_count;
    int          pending;
    bit          idle_on;
    bit          hold_off_req;
    int          cur_len;

    longest_equal_run_tracker u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    lert_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    // result side: random idle bursts, plus long hold-offs while one is requested
    initial begin
        int hold;
        int gap;
        hold = 0;
        gap  = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && hold == 0) begin
                hold = 400;
            end
            if (hold > 1) begin
                m_tready <= 1'b0;
                hold--;
            end else if (gap > 0) begin
                m_tready <= 1'b0;
                gap--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                gap = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b1;
                hold = 0;
            end
        end
    end

    task automatic send_write(input logic [9:0] pos, input logic [7:0] ch);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, ch, pos};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_length(input logic [10:0] len);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_len = (len == 0) ? 1 : (len > MAX_LEAVES) ? MAX_LEAVES : len;
    endtask

    // mostly in-range writes from a tiny alphabet so runs grow and merge
    task automatic random_writes(input int count);
        logic [9:0] pos;
        logic [7:0] ch;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                pos = 10'($urandom);
            end else begin
                pos = 10'($urandom_range(0, cur_len - 1));
            end
            if ($urandom_range(0, 7) == 0) begin
                ch = 8'($urandom);
            end else begin
                ch = $urandom_range(0, 1) ? 8'hff : 8'h00;
            end
            send_write(pos, ch);
        end
    endtask

    initial begin
        logic [10:0] lens [8] = '{11'd1, 11'd0, 11'd2047, 11'd1024,
                                  11'd5, 11'd37, 11'd1000, 11'd300};
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        idle_on      = 1'b1;
        hold_off_req = 1'b0;
        cur_len      = MAX_LEAVES;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes of position and character at full length
        send_write(10'd0, 8'hff);
        send_write(10'd1023, 8'hff);
        send_write(10'd1023, 8'h00);
        send_write(10'd512, 8'haa);
        send_write(10'd511, 8'h55);
        send_write(10'd0, 8'h00);
        send_write(10'd513, 8'haa);
        send_write(10'd514, 8'haa);
        send_write(10'd512, 8'h00);
        set_length(11'd1);
        send_write(10'd0, 8'h7f);
        send_write(10'd1, 8'h7f);        // out of range
        send_write(10'd1023, 8'h00);     // out of range
        set_length(11'd0);               // raised to one
        send_write(10'd1, 8'h01);
        send_write(10'd0, 8'h80);
        set_length(11'd2047);            // lowered to the maximum
        send_write(10'd1023, 8'h01);
        send_write(10'd700, 8'h02);

        // long hold-off on the result side while requests keep coming
        hold_off_req <= 1'b1;
        random_writes(30);
        hold_off_req <= 1'b0;

        for (int p = 0; p < 8; p++) begin
            set_length(lens[p]);
            random_writes(80);
        end
        idle_on = 1'b0;
        random_writes(150);

        wait_quiet();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
